### sv/u8d_pkg.sv
// Shared types and constants for the UTF-8 sequence decoder.
`timescale 1ns / 1ps

package u8d_pkg;

   localparam int NumLanes = 3;

   localparam logic [7:0] ContLo  = 8'h80;
   localparam logic [7:0] ContHi  = 8'hBF;
   localparam logic [7:0] E0Lo    = 8'hA0;
   localparam logic [7:0] EdHi    = 8'h9F;
   localparam logic [7:0] F0Lo    = 8'h90;
   localparam logic [7:0] F4Hi    = 8'h8F;
   localparam logic [7:0] Mask2   = 8'h1F;
   localparam logic [7:0] Mask3   = 8'h0F;
   localparam logic [7:0] Mask4   = 8'h07;
   localparam logic [7:0] PayMask = 8'h3F;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_BAD   = 2'd1,
      ST_SHORT = 2'd2
   } status_type;

   // what the lead byte implies
   typedef struct packed {
      logic       is_ascii;
      logic       is_bad;
      logic [2:0] len;
      logic [4:0] lead_bits;
      logic [7:0] lo;
      logic [7:0] hi;
   } lead_type;

   // what one trailing-byte lane found
   typedef struct packed {
      logic       ok;
      logic [5:0] payload;
   } lane_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  consumed;
      logic [2:0]  seq_len;
      logic [20:0] code_point;
   } result_type;

endpackage

### sv/u8d_lead.sv
// Lead byte decoder: sequence length, payload bits and second-byte range.
`timescale 1ns / 1ps

module u8d_lead (
   input  logic [7:0]        byte0,
   output u8d_pkg::lead_type lead
);

   logic [7:0] masked;

   always_comb begin
      lead           = '0;
      lead.lo        = u8d_pkg::ContLo;
      lead.hi        = u8d_pkg::ContHi;
      lead.len       = 3'd1;
      masked         = 8'h00;
      unique case (byte0) inside
         [8'h00:8'h7F]: begin
            lead.is_ascii = 1'b1;
         end
         [8'hC2:8'hDF]: begin
            lead.len = 3'd2;
            masked   = byte0 & u8d_pkg::Mask2;
         end
         [8'hE0:8'hEF]: begin
            lead.len = 3'd3;
            masked   = byte0 & u8d_pkg::Mask3;
            if (byte0 == 8'hE0) lead.lo = u8d_pkg::E0Lo;
            if (byte0 == 8'hED) lead.hi = u8d_pkg::EdHi;   // keeps surrogates out
         end
         [8'hF0:8'hF4]: begin
            lead.len = 3'd4;
            masked   = byte0 & u8d_pkg::Mask4;
            if (byte0 == 8'hF0) lead.lo = u8d_pkg::F0Lo;
            if (byte0 == 8'hF4) lead.hi = u8d_pkg::F4Hi;   // nothing above U+10FFFF
         end
         default: begin
            lead.is_bad = 1'b1;
         end
      endcase
      lead.lead_bits = masked[4:0];
   end

endmodule

### sv/u8d_lane.sv
// One trailing-byte lane: continuation and range check, payload extract.
`timescale 1ns / 1ps

module u8d_lane (
   input  logic [7:0]        data,
   input  logic [7:0]        lo,
   input  logic [7:0]        hi,
   output u8d_pkg::lane_type lane
);

   logic [7:0] pay;

   assign pay          = data & u8d_pkg::PayMask;
   assign lane.ok      = (data[7:6] == 2'b10) && (data >= lo) && (data <= hi);
   assign lane.payload = pay[5:0];

endmodule

### sv/u8d_merge.sv
// Merges lead and lane findings into one result item.
`timescale 1ns / 1ps

module u8d_merge (
   input  logic [7:0]                              byte0,
   input  logic [2:0]                              avail,
   input  u8d_pkg::lead_type                       lead,
   input  u8d_pkg::lane_type [u8d_pkg::NumLanes-1:0] lanes,
   output u8d_pkg::result_type                     result
);

   logic [2:0]  navail;
   logic [20:0] cp;

   always_comb begin
      navail = avail;
      if (avail > 3'd4) navail = 3'd4;
      if (avail == 3'd0) navail = 3'd1;
   end

   always_comb begin
      case (lead.len)
         3'd2:    cp = {10'd0, lead.lead_bits, lanes[0].payload};
         3'd3:    cp = {5'd0, lead.lead_bits[3:0], lanes[0].payload, lanes[1].payload};
         default: cp = {lead.lead_bits[2:0], lanes[0].payload, lanes[1].payload,
                        lanes[2].payload};
      endcase
   end

   always_comb begin
      result.status     = u8d_pkg::ST_OK;
      result.consumed   = lead.len;
      result.seq_len    = lead.len;
      result.code_point = cp;
      if (lead.is_ascii) begin
         result.consumed   = 3'd1;
         result.seq_len    = 3'd1;
         result.code_point = {13'd0, byte0};
      end else if (lead.is_bad) begin
         result.status     = u8d_pkg::ST_BAD;
         result.consumed   = 3'd1;
         result.seq_len    = 3'd1;
         result.code_point = '0;
      end else if (navail < lead.len) begin
         // short window wins over any bad byte inside it
         result.status     = u8d_pkg::ST_SHORT;
         result.consumed   = navail;
         result.code_point = '0;
      end else if (!lanes[0].ok) begin
         result.status     = u8d_pkg::ST_BAD;
         result.consumed   = 3'd2;
         result.code_point = '0;
      end else if (lead.len >= 3'd3 && !lanes[1].ok) begin
         result.status     = u8d_pkg::ST_BAD;
         result.consumed   = 3'd3;
         result.code_point = '0;
      end else if (lead.len == 3'd4 && !lanes[2].ok) begin
         result.status     = u8d_pkg::ST_BAD;
         result.consumed   = 3'd4;
         result.code_point = '0;
      end
   end

endmodule

### sv/utf8_sequence_decoder.sv
// Top level of the strict UTF-8 sequence decoder.
// Usage:
//  - req_ channel: one item per handshake, a window of up to four bytes from
//    the head of a string (req_byte0 is the lead byte) and req_avail, the
//    bytes present there (values above four count as four, zero as one).
//  - rsp_ channel: one item per request: status (ok, invalid, incomplete),
//    bytes to advance, sequence length and the decoded code point.
//  - Throughput is one item per cycle while the receiver does not stall.
//    The lead decoder and three trailing-byte lanes work in parallel and
//    the merge step sits in front of the output register.
//  - A two-entry output buffer (output register plus skid register) lets
//    req_ready depend only on local state; when the receiver stalls, one more
//    item is taken into the skid register, then req_ready drops until the
//    receiver takes an item.
//  - Reset empties both output entries; no other state is kept.
`timescale 1ns / 1ps

module utf8_sequence_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte0,
   input  logic [7:0]  req_byte1,
   input  logic [7:0]  req_byte2,
   input  logic [7:0]  req_byte3,
   input  logic [2:0]  req_avail,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_consumed,
   output logic [2:0]  rsp_seq_len,
   output logic [20:0] rsp_code_point
);

   u8d_pkg::lead_type                        lead;
   u8d_pkg::lane_type [u8d_pkg::NumLanes-1:0] lanes;
   u8d_pkg::result_type                      result;

   u8d_lead u_lead (
      .byte0 (req_byte0),
      .lead  (lead)
   );

   // only the second byte carries the lead-specific range
   u8d_lane u_lane1 (
      .data (req_byte1),
      .lo   (lead.lo),
      .hi   (lead.hi),
      .lane (lanes[0])
   );

   u8d_lane u_lane2 (
      .data (req_byte2),
      .lo   (u8d_pkg::ContLo),
      .hi   (u8d_pkg::ContHi),
      .lane (lanes[1])
   );

   u8d_lane u_lane3 (
      .data (req_byte3),
      .lo   (u8d_pkg::ContLo),
      .hi   (u8d_pkg::ContHi),
      .lane (lanes[2])
   );

   u8d_merge u_merge (
      .byte0  (req_byte0),
      .avail  (req_avail),
      .lead   (lead),
      .lanes  (lanes),
      .result (result)
   );

   // output buffer
   logic                main_valid_ff, main_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   u8d_pkg::result_type main_ff, main_in;
   u8d_pkg::result_type skid_ff, skid_in;
   logic                accept;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = result;
            main_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid      = main_valid_ff;
   assign rsp_status     = main_ff.status;
   assign rsp_consumed   = main_ff.consumed;
   assign rsp_seq_len    = main_ff.seq_len;
   assign rsp_code_point = main_ff.code_point;

endmodule
